// File: hdl/unwind_region_header_encoder_top_assert.svh
// Assertion macros used by the checker file of the encoder.
// Both macros sample on the rising edge of clk and are off while arst_n is low.
`ifndef UNWIND_REGION_HEADER_ENCODER_TOP_ASSERT_SVH
`define UNWIND_REGION_HEADER_ENCODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URHE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define URHE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/urhe_pkg.sv
`default_nettype none

package urhe_pkg;

	localparam int WORD_W = 32;

	// Longest ULEB128 length field that may be emitted.
	localparam logic [3:0] LEB_MAX_BYTES = 4'd8;

	localparam logic [1:0] CMD_PROLOGUE  = 2'd0;
	localparam logic [1:0] CMD_PROLOGUE_SAVED = 2'd1;
	localparam logic [1:0] CMD_BODY      = 2'd2;
	localparam logic [1:0] CMD_NEW_PROC  = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_SIZE      = 2'd1;
	localparam logic [1:0] STATUS_ARG       = 2'd2;
	localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

	localparam logic [7:0] R1_PROLOGUE = 8'h00;
	localparam logic [7:0] R1_BODY     = 8'h20;
	localparam logic [7:0] R2_BASE     = 8'h40;
	localparam logic [7:0] R3_PROLOGUE = 8'h60;
	localparam logic [7:0] R3_BODY     = 8'h61;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [WORD_W-1:0] region_length;
		logic [7:0]        save_mask;
		logic [WORD_W-1:0] save_register;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [1:0] status;
		logic       last;
	} out_item_t;

endpackage

`default_nettype wire

// File: hdl/unwind_region_header_encoder_top.sv
// Channel   Signals                                Direction  Item
// in        in_valid, in_ready, in_data            in         one request
// out       out_valid, out_ready, out_data         out        one result byte or status
// cfg       cfg_valid, cfg_ready, cfg_data         in         procedure total length
//
// A new-procedure request yields one status item; a region request passes its summing and
// limit check (ADD_LO, ADD_HI, CHECK) through the single 32-bit adder, then emits one result
// item per cycle (one to seven) while the out channel is free. Results leave through one
// output register; a stalled out channel holds the sequencer in its emit step.
// Reset clears the running sum, the limit and all control state; no clearing pass.
`default_nettype none

module unwind_region_header_encoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  urhe_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output urhe_pkg::out_item_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [urhe_pkg::WORD_W-1:0] cfg_data
);
	import urhe_pkg::*;

	logic      out_valid_q;
	out_item_t out_data_q;
	logic      slot_free;
	logic      push;
	out_item_t item;

	assign slot_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	urhe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.slot_free (slot_free),
		.push      (push),
		.item      (item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q <= item;
		end
	end

endmodule

`default_nettype wire

// File: hdl/urhe_alu.sv
`default_nettype none

module urhe_alu (
	input  logic [urhe_pkg::WORD_W-1:0] a,
	input  logic [urhe_pkg::WORD_W-1:0] b,
	input  logic                        cin,
	output logic [urhe_pkg::WORD_W-1:0] sum,
	output logic                        cout
);
	import urhe_pkg::*;

	assign {cout, sum} = {1'b0, a} + {1'b0, b} + {{WORD_W{1'b0}}, cin};

endmodule

`default_nettype wire

// File: hdl/urhe_ctrl.sv
`default_nettype none

module urhe_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  urhe_pkg::in_item_t          in_data,
	input  logic                        cfg_valid,
	input  logic [urhe_pkg::WORD_W-1:0] cfg_data,
	input  logic                        slot_free,
	output logic                        push,
	output urhe_pkg::out_item_t         item
);
	import urhe_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ADD_LO = 5'b00010,
		ST_ADD_HI = 5'b00100,
		ST_CHECK  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [1:0]        cmd_q;
	logic [WORD_W-1:0] len_q;
	logic [3:0]        mask_q;
	logic              mask_bad_q;
	logic [6:0]        reg_q;
	logic              reg_bad_q;
	logic [WORD_W-1:0] sum_lo_q;
	logic [WORD_W-1:0] sum_hi_q;
	logic              carry_q;
	logic [WORD_W-1:0] total_q;
	logic [15:0]       hdr_q;
	logic [1:0]        hdr_cnt_q;
	logic              leb_on_q;
	logic [WORD_W-1:0] leb_q;
	logic [1:0]        status_q;
	logic              single_q;

	logic [WORD_W-1:0] alu_a;
	logic [WORD_W-1:0] alu_b;
	logic              alu_cin;
	logic [WORD_W-1:0] alu_sum;
	logic              alu_cout;
	logic [3:0]        leb_cnt;
	logic              too_long;
	logic              size_err;
	logic              leb_more;

	// One adder serves the low half, the high half with carry, and the limit compare.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_cin = 1'b0;
		unique case (state_q)
			ST_ADD_LO: begin
				alu_a = sum_lo_q;
				alu_b = len_q;
			end
			ST_ADD_HI: begin
				alu_a   = sum_hi_q;
				alu_cin = carry_q;
			end
			ST_CHECK: begin
				alu_a   = total_q;
				alu_b   = ~sum_lo_q;
				alu_cin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	urhe_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.cin  (alu_cin),
		.sum  (alu_sum),
		.cout (alu_cout)
	);

	// A missing carry out of total - sum_lo means the low half exceeds the limit.
	assign size_err = (sum_hi_q != '0) || !alu_cout;

	always_comb begin
		if (len_q[31:28] != '0) begin
			leb_cnt = 4'd5;
		end else if (len_q[27:21] != '0) begin
			leb_cnt = 4'd4;
		end else if (len_q[20:14] != '0) begin
			leb_cnt = 4'd3;
		end else if (len_q[13:7] != '0) begin
			leb_cnt = 4'd2;
		end else begin
			leb_cnt = 4'd1;
		end
	end

	assign too_long = leb_cnt > LEB_MAX_BYTES;
	assign leb_more = leb_q[WORD_W-1:7] != '0;
	assign in_ready = state_q == ST_IDLE;
	assign push     = (state_q == ST_EMIT) && slot_free;

	always_comb begin
		if (single_q) begin
			item = '{out_byte: 8'h00, byte_valid: 1'b0, status: status_q, last: 1'b1};
		end else if (hdr_cnt_q != 2'd0) begin
			item = '{out_byte: hdr_q[15:8], byte_valid: 1'b1, status: STATUS_OK,
				last: (hdr_cnt_q == 2'd1) && !leb_on_q};
		end else begin
			item = '{out_byte: {leb_more, leb_q[6:0]}, byte_valid: 1'b1,
				status: STATUS_OK, last: !leb_more};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_lo_q  <= '0;
			sum_hi_q  <= '0;
			total_q   <= '0;
			hdr_cnt_q <= '0;
			leb_on_q  <= 1'b0;
			single_q  <= 1'b0;
			status_q  <= STATUS_OK;
			carry_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				total_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_data.cmd == CMD_NEW_PROC) begin
							sum_lo_q <= '0;
							sum_hi_q <= '0;
							status_q <= STATUS_OK;
							single_q <= 1'b1;
							state_q  <= ST_EMIT;
						end else begin
							state_q <= ST_ADD_LO;
						end
					end
				end
				ST_ADD_LO: begin
					sum_lo_q <= alu_sum;
					carry_q  <= alu_cout;
					state_q  <= ST_ADD_HI;
				end
				ST_ADD_HI: begin
					if (alu_cout) begin
						sum_lo_q <= '1;
						sum_hi_q <= '1;
					end else begin
						sum_hi_q <= alu_sum;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					single_q <= 1'b0;
					status_q <= STATUS_OK;
					leb_q    <= len_q;
					if (size_err) begin
						status_q <= STATUS_SIZE;
						single_q <= 1'b1;
					end else if (cmd_q == CMD_PROLOGUE_SAVED) begin
						if (mask_bad_q || reg_bad_q) begin
							status_q <= STATUS_ARG;
							single_q <= 1'b1;
						end else if (too_long) begin
							status_q <= STATUS_TOO_LONG;
							single_q <= 1'b1;
						end
						hdr_q     <= {R2_BASE | {5'b0, mask_q[3:1]}, mask_q[0], reg_q};
						hdr_cnt_q <= 2'd2;
						leb_on_q  <= 1'b1;
					end else if (len_q[WORD_W-1:5] == '0) begin
						hdr_q     <= {((cmd_q == CMD_PROLOGUE) ? R1_PROLOGUE : R1_BODY)
							| {3'b0, len_q[4:0]}, 8'h00};
						hdr_cnt_q <= 2'd1;
						leb_on_q  <= 1'b0;
					end else begin
						if (too_long) begin
							status_q <= STATUS_TOO_LONG;
							single_q <= 1'b1;
						end
						hdr_q     <= {((cmd_q == CMD_PROLOGUE) ? R3_PROLOGUE : R3_BODY), 8'h00};
						hdr_cnt_q <= 2'd1;
						leb_on_q  <= 1'b1;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (push) begin
						if (item.last) begin
							state_q <= ST_IDLE;
						end
						if (!single_q) begin
							if (hdr_cnt_q != 2'd0) begin
								hdr_q     <= {hdr_q[7:0], 8'h00};
								hdr_cnt_q <= hdr_cnt_q - 2'd1;
							end else begin
								leb_q <= {7'b0, leb_q[WORD_W-1:7]};
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields are captured once and held for the whole sequence.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q      <= in_data.cmd;
			len_q      <= in_data.region_length;
			mask_q     <= in_data.save_mask[3:0];
			mask_bad_q <= in_data.save_mask[7:4] != '0;
			reg_q      <= in_data.save_register[6:0];
			reg_bad_q  <= in_data.save_register[WORD_W-1:7] != '0;
		end
	end

endmodule

`default_nettype wire

// File: hdl/urhe_checker.sv
`default_nettype none

`include "unwind_region_header_encoder_top_assert.svh"

module urhe_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input urhe_pkg::out_item_t         out_data
);
	import urhe_pkg::*;

	// A request is worked on alone, so the input closes right after an item is taken.
	`URHE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
		"input still ready after an item was accepted")

	`URHE_ASSERT_SAME(a_byte_is_ok, out_valid && out_data.byte_valid,
		out_data.status == STATUS_OK, "descriptor byte carries an error status")

	`URHE_ASSERT_SAME(a_error_alone, out_valid && (out_data.status != STATUS_OK),
		out_data.last && !out_data.byte_valid, "error result is not a lone final item")

	`URHE_ASSERT_SAME(a_empty_is_zero, out_valid && !out_data.byte_valid,
		out_data.out_byte == 8'h00, "non-byte result carries a nonzero byte")

	`URHE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_data), "stalled output item changed")

endmodule

bind unwind_region_header_encoder_top urhe_checker u_urhe_checker (.*);

`default_nettype wire
